// ===== rtl/lph_pkg.sv =====
`timescale 1ns / 1ps

package lph_pkg;

    localparam int KEY_W    = 31;
    localparam int PID_W    = 31;
    localparam int TIME_W   = 32;
    localparam int TYPE_W   = 8;
    localparam int REC_W    = PID_W + TIME_W + TYPE_W;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int ENTRY_W  = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK
    } t_state;

    typedef struct packed {
        logic key_we;
        logic key_vld;
        logic rec_we;
    } t_wr_ctl;

endpackage

// ===== rtl/lph_mod_unit.sv =====
`timescale 1ns / 1ps

module lph_mod_unit #(
    parameter int TABLE_SIZE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lph_pkg::KEY_W-1:0]     i_key,
    output logic                          o_done,
    output logic [$clog2(TABLE_SIZE)-1:0] o_rem
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int SHIFT   = lph_pkg::KEY_W + IDX_W;
    localparam int RECIP_W = lph_pkg::KEY_W + 1;
    localparam int PROD_W  = lph_pkg::KEY_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
    localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_FULL);
    localparam logic [IDX_W-1:0]   DIV_LO = IDX_W'(TABLE_SIZE);

    logic                        r_v_key, r_v_prod, r_v_rem;
    logic [lph_pkg::KEY_W-1:0]   r_key;
    logic [PROD_W-1:0]           r_prod;
    logic [IDX_W-1:0]            r_rem;
    logic [IDX_W-1:0]            w_quot_lo;
    logic [IDX_W-1:0]            w_qm_lo;

    // quotient by rounded-up reciprocal, exact for every key width value
    // remainder needs only the low bits of key and quotient times size
    assign w_quot_lo = r_prod[SHIFT +: IDX_W];
    assign w_qm_lo   = IDX_W'(w_quot_lo * DIV_LO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_key  <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_rem  <= 1'b0;
        end else begin
            r_v_key  <= i_start;
            r_v_prod <= r_v_key;
            r_v_rem  <= r_v_prod;
        end
        if (i_start) begin
            r_key <= i_key;
        end
        r_prod <= r_key * RECIP;
        r_rem  <= r_key[IDX_W-1:0] - w_qm_lo;
    end

    assign o_done = r_v_rem;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/lph_store.sv =====
`timescale 1ns / 1ps

module lph_store #(
    parameter int TABLE_SIZE = 64
) (
    input  logic                          i_clk,
    input  lph_pkg::t_wr_ctl              i_wr,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_addr,
    input  logic [lph_pkg::KEY_W-1:0]     i_key,
    input  logic [lph_pkg::REC_W-1:0]     i_rec,
    output logic                          o_vld,
    output logic [lph_pkg::KEY_W-1:0]     o_key,
    output logic [lph_pkg::REC_W-1:0]     o_rec
);

    logic [lph_pkg::KEY_W:0]   r_key_mem [TABLE_SIZE];
    logic [lph_pkg::REC_W-1:0] r_rec_mem [TABLE_SIZE];
    logic [lph_pkg::KEY_W:0]   r_key_rd;
    logic [lph_pkg::REC_W-1:0] r_rec_rd;

    // valid bit kept alongside the key
    always_ff @(posedge i_clk) begin
        if (i_wr.key_we) begin
            r_key_mem[i_addr] <= {i_wr.key_vld, i_key};
        end
        r_key_rd <= r_key_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.rec_we) begin
            r_rec_mem[i_addr] <= i_rec;
        end
        r_rec_rd <= r_rec_mem[i_addr];
    end

    assign o_vld = r_key_rd[lph_pkg::KEY_W];
    assign o_key = r_key_rd[lph_pkg::KEY_W-1:0];
    assign o_rec = r_rec_rd;

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
`timescale 1ns / 1ps
// result path: key modulo by reciprocal multiply (key, product and remainder registers), then a read state
//   and a check state per slot probed, 1 to TABLE_SIZE probes
// issue: one item at a time, next transfer accepted once the result is registered;
//   a result waiting on i_ready holds the last probe
// reset: a clearing pass writes every slot empty, o_ready low meanwhile;
//   the entry count resets to zero
module linear_probe_hash_table #(
    parameter int TABLE_SIZE = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [lph_pkg::CMD_W-1:0]      i_cmd,
    input  logic [lph_pkg::KEY_W-1:0]      i_key,
    input  logic [lph_pkg::PID_W-1:0]      i_value_pid,
    input  logic [lph_pkg::TIME_W-1:0]     i_value_time,
    input  logic [lph_pkg::TYPE_W-1:0]     i_value_type,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [lph_pkg::STATUS_W-1:0]   o_status,
    output logic [lph_pkg::SLOT_W-1:0]     o_slot_index,
    output logic [lph_pkg::PID_W-1:0]      o_found_pid,
    output logic [lph_pkg::TIME_W-1:0]     o_found_time,
    output logic [lph_pkg::TYPE_W-1:0]     o_found_type,
    output logic [lph_pkg::ENTRY_W-1:0]    o_entry_count
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    lph_pkg::t_state             r_state, n_state;
    logic [IDX_W-1:0]            r_idx, n_idx;
    logic [IDX_W-1:0]            r_n, n_n;
    logic [CNT_W-1:0]            r_count, n_count;

    logic [lph_pkg::CMD_W-1:0]   r_cmd;
    logic [lph_pkg::KEY_W-1:0]   r_key;
    logic [lph_pkg::REC_W-1:0]   r_rec;

    logic                        r_out_valid, n_out_valid;
    logic [lph_pkg::STATUS_W-1:0] r_status, n_status;
    logic [IDX_W-1:0]            r_slot, n_slot;
    logic [lph_pkg::PID_W-1:0]   r_fpid, n_fpid;
    logic [lph_pkg::TIME_W-1:0]  r_ftime, n_ftime;
    logic [lph_pkg::TYPE_W-1:0]  r_ftype, n_ftype;

    lph_pkg::t_wr_ctl            w_wr;
    logic                        w_accept;
    logic                        w_mod_done;
    logic [IDX_W-1:0]            w_mod_rem;
    logic                        w_rd_vld;
    logic [lph_pkg::KEY_W-1:0]   w_rd_key;
    logic [lph_pkg::REC_W-1:0]   w_rd_rec;
    logic                        w_hit;
    logic                        w_out_free;

    assign o_ready  = (r_state == lph_pkg::S_IDLE);
    assign w_accept = i_valid && o_ready;

    lph_mod_unit #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_accept),
        .i_key  (i_key),
        .o_done (w_mod_done),
        .o_rem  (w_mod_rem)
    );

    lph_store #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_store (
        .i_clk (i_clk),
        .i_wr  (w_wr),
        .i_addr(r_idx),
        .i_key (r_key),
        .i_rec (r_rec),
        .o_vld (w_rd_vld),
        .o_key (w_rd_key),
        .o_rec (w_rd_rec)
    );

    assign w_hit      = w_rd_vld && (w_rd_key == r_key);
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_n         = r_n;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_slot      = r_slot;
        n_fpid      = r_fpid;
        n_ftime     = r_ftime;
        n_ftype     = r_ftype;
        w_wr        = '0;
        unique case (r_state)
            lph_pkg::S_CLEAR: begin
                w_wr.key_we = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = lph_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            lph_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = lph_pkg::S_HASH;
                end
            end
            lph_pkg::S_HASH: begin
                if (w_mod_done) begin
                    n_idx   = w_mod_rem;
                    n_n     = '0;
                    n_state = lph_pkg::S_READ;
                end
            end
            lph_pkg::S_READ: begin
                n_state = lph_pkg::S_CHECK;
            end
            lph_pkg::S_CHECK: begin
                if (!w_rd_vld || w_hit || (r_n == LAST_IDX)) begin
                    if (w_out_free) begin
                        n_state     = lph_pkg::S_IDLE;
                        n_out_valid = 1'b1;
                        n_status    = lph_pkg::ST_MISSING;
                        n_slot      = '0;
                        n_fpid      = '0;
                        n_ftime     = '0;
                        n_ftype     = '0;
                        case (r_cmd)
                            lph_pkg::CMD_INSERT: begin
                                if (w_hit) begin
                                    n_status    = lph_pkg::ST_UPDATED;
                                    n_slot      = r_idx;
                                    w_wr.rec_we = 1'b1;
                                end else if (!w_rd_vld) begin
                                    n_status     = lph_pkg::ST_INSERTED;
                                    n_slot       = r_idx;
                                    w_wr.key_we  = 1'b1;
                                    w_wr.key_vld = 1'b1;
                                    w_wr.rec_we  = 1'b1;
                                    n_count      = r_count + 1'b1;
                                end else begin
                                    n_status = lph_pkg::ST_FULL;
                                end
                            end
                            lph_pkg::CMD_LOOKUP: begin
                                if (w_hit) begin
                                    n_status = lph_pkg::ST_FOUND;
                                    n_slot   = r_idx;
                                    n_fpid   = w_rd_rec[lph_pkg::REC_W-1 -: lph_pkg::PID_W];
                                    n_ftime  = w_rd_rec[lph_pkg::TYPE_W +: lph_pkg::TIME_W];
                                    n_ftype  = w_rd_rec[lph_pkg::TYPE_W-1:0];
                                end
                            end
                            lph_pkg::CMD_DELETE: begin
                                if (w_hit) begin
                                    n_status    = lph_pkg::ST_DELETED;
                                    n_slot      = r_idx;
                                    w_wr.key_we = 1'b1;
                                    if (r_count != '0) begin
                                        n_count = r_count - 1'b1;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end else begin
                    n_idx   = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                    n_n     = r_n + 1'b1;
                    n_state = lph_pkg::S_READ;
                end
            end
            default: begin
                n_state = lph_pkg::S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lph_pkg::S_CLEAR;
            r_idx       <= '0;
            r_n         <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, held from transfer to result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
            r_rec <= {i_value_pid, i_value_time, i_value_type};
        end
        r_status <= n_status;
        r_slot   <= n_slot;
        r_fpid   <= n_fpid;
        r_ftime  <= n_ftime;
        r_ftype  <= n_ftype;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_slot_index  = lph_pkg::SLOT_W'(r_slot);
    assign o_found_pid   = r_fpid;
    assign o_found_time  = r_ftime;
    assign o_found_type  = r_ftype;
    assign o_entry_count = lph_pkg::ENTRY_W'(r_count);

endmodule

// ===== tb/sv/linear_probe_hash_table_tb.sv =====
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;

    localparam int SLOTS = 64;
    localparam int POOL_SIZE = 24;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [lph_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic TYPED = 1'b1;
    localparam logic PREDICT = 1'b0;

    typedef struct packed {
        logic [lph_pkg::CMD_W-1:0]  cmd;
        logic [lph_pkg::KEY_W-1:0]  key;
        logic [lph_pkg::PID_W-1:0]  pid;
        logic [lph_pkg::TIME_W-1:0] stamp;
        logic [lph_pkg::TYPE_W-1:0] kind;
    } t_op;

    typedef struct packed {
        logic [lph_pkg::STATUS_W-1:0] status;
        logic [lph_pkg::SLOT_W-1:0]   slot;
        logic [lph_pkg::PID_W-1:0]    pid;
        logic [lph_pkg::TIME_W-1:0]   stamp;
        logic [lph_pkg::TYPE_W-1:0]   kind;
        logic [lph_pkg::ENTRY_W-1:0]  count;
    } t_reply;

    typedef struct packed {
        t_op    op;
        logic   typed;
        t_reply reply;
    } t_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [lph_pkg::CMD_W-1:0]    i_cmd;
    logic [lph_pkg::KEY_W-1:0]    i_key;
    logic [lph_pkg::PID_W-1:0]    i_value_pid;
    logic [lph_pkg::TIME_W-1:0]   i_value_time;
    logic [lph_pkg::TYPE_W-1:0]   i_value_type;
    logic                         o_valid;
    logic                         i_ready;
    logic [lph_pkg::STATUS_W-1:0] o_status;
    logic [lph_pkg::SLOT_W-1:0]   o_slot_index;
    logic [lph_pkg::PID_W-1:0]    o_found_pid;
    logic [lph_pkg::TIME_W-1:0]   o_found_time;
    logic [lph_pkg::TYPE_W-1:0]   o_found_type;
    logic [lph_pkg::ENTRY_W-1:0]  o_entry_count;

    // shadow copy of the table
    logic                         shadow_valid [SLOTS];
    logic [lph_pkg::KEY_W-1:0]    shadow_key   [SLOTS];
    logic [lph_pkg::PID_W-1:0]    shadow_pid   [SLOTS];
    logic [lph_pkg::TIME_W-1:0]   shadow_stamp [SLOTS];
    logic [lph_pkg::TYPE_W-1:0]   shadow_kind  [SLOTS];
    int unsigned                  shadow_count;

    t_reply                       replies_due[$];
    t_row                         directed_rows[$];
    logic [lph_pkg::KEY_W-1:0]    key_pool [POOL_SIZE];
    int                           fail_count = 0;
    int                           hold_off = 0;
    bit                           idle_on = 1'b1;

    linear_probe_hash_table #(
        .TABLE_SIZE(SLOTS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_key        (i_key),
        .i_value_pid  (i_value_pid),
        .i_value_time (i_value_time),
        .i_value_type (i_value_type),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_slot_index (o_slot_index),
        .o_found_pid  (o_found_pid),
        .o_found_time (o_found_time),
        .o_found_type (o_found_type),
        .o_entry_count(o_entry_count)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_reply apply_to_shadow_table(input t_op op);
        t_reply r;
        int     idx;
        int     pos;
        int     n;
        bit     hit;
        bit     empty;
        r = '0;
        r.status = lph_pkg::ST_MISSING;
        hit = 1'b0;
        empty = 1'b0;
        pos = 0;
        idx = int'(op.key % SLOTS);
        if (op.cmd != CMD_UNUSED) begin
            for (n = 0; n < SLOTS && !hit && !empty; n++) begin
                if (!shadow_valid[idx]) begin
                    empty = 1'b1;
                    pos = idx;
                end else if (shadow_key[idx] == op.key) begin
                    hit = 1'b1;
                    pos = idx;
                end else begin
                    idx = (idx + 1) % SLOTS;
                end
            end
        end
        case (op.cmd)
            lph_pkg::CMD_INSERT: begin
                if (hit) begin
                    r.status = lph_pkg::ST_UPDATED;
                end else if (empty) begin
                    shadow_valid[pos] = 1'b1;
                    shadow_key[pos] = op.key;
                    shadow_count++;
                    r.status = lph_pkg::ST_INSERTED;
                end else begin
                    r.status = lph_pkg::ST_FULL;
                end
                if (hit || empty) begin
                    r.slot = lph_pkg::SLOT_W'(pos);
                    shadow_pid[pos] = op.pid;
                    shadow_stamp[pos] = op.stamp;
                    shadow_kind[pos] = op.kind;
                end
            end
            lph_pkg::CMD_LOOKUP: begin
                if (hit) begin
                    r.status = lph_pkg::ST_FOUND;
                    r.slot = lph_pkg::SLOT_W'(pos);
                    r.pid = shadow_pid[pos];
                    r.stamp = shadow_stamp[pos];
                    r.kind = shadow_kind[pos];
                end
            end
            lph_pkg::CMD_DELETE: begin
                if (hit) begin
                    shadow_valid[pos] = 1'b0;
                    if (shadow_count > 0) shadow_count--;
                    r.status = lph_pkg::ST_DELETED;
                    r.slot = lph_pkg::SLOT_W'(pos);
                end
            end
            default: ;
        endcase
        r.count = lph_pkg::ENTRY_W'(shadow_count);
        return r;
    endfunction

    function automatic void add_row(input logic [lph_pkg::CMD_W-1:0] cmd,
            input logic [lph_pkg::KEY_W-1:0] key, input logic [lph_pkg::PID_W-1:0] pid,
            input logic [lph_pkg::TIME_W-1:0] stamp, input logic [lph_pkg::TYPE_W-1:0] kind,
            input logic typed, input logic [lph_pkg::STATUS_W-1:0] status,
            input logic [lph_pkg::SLOT_W-1:0] slot, input logic [lph_pkg::ENTRY_W-1:0] count);
        t_row row;
        row = '0;
        row.op = '{cmd, key, pid, stamp, kind};
        row.typed = typed;
        row.reply.status = status;
        row.reply.slot = slot;
        row.reply.count = count;
        directed_rows.push_back(row);
    endfunction

    function automatic t_op make_op(input logic [lph_pkg::CMD_W-1:0] cmd,
            input logic [lph_pkg::KEY_W-1:0] key);
        t_op op;
        op.cmd = cmd;
        op.key = key;
        op.pid = lph_pkg::PID_W'($urandom);
        op.stamp = $urandom;
        op.kind = lph_pkg::TYPE_W'($urandom);
        return op;
    endfunction

    function automatic logic [lph_pkg::CMD_W-1:0] mixed_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return lph_pkg::CMD_INSERT;
        if (r < 78) return lph_pkg::CMD_LOOKUP;
        if (r < 95) return lph_pkg::CMD_DELETE;
        return CMD_UNUSED;
    endfunction

    function automatic logic [lph_pkg::KEY_W-1:0] pool_key();
        if ($urandom_range(0, 99) < 8) return lph_pkg::KEY_W'($urandom);
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [lph_pkg::KEY_W-1:0] stored_key();
        int s;
        int n;
        s = $urandom_range(0, SLOTS - 1);
        for (n = 0; n < SLOTS; n++) begin
            if (shadow_valid[(s + n) % SLOTS]) return shadow_key[(s + n) % SLOTS];
        end
        return lph_pkg::KEY_W'($urandom);
    endfunction

    task automatic send_op(input t_op op, input logic typed, input t_reply reply);
        t_reply want;
        int     gap;
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= op.cmd;
        i_key        <= op.key;
        i_value_pid  <= op.pid;
        i_value_time <= op.stamp;
        i_value_type <= op.kind;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        want = apply_to_shadow_table(op);
        if (typed) want = reply;
        replies_due.push_back(want);
    endtask

    task automatic wait_all_replies();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic void compare_field(input string name, input longint unsigned want,
            input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // result side: checks every transfer, stalls at random while idle_on and holds off for hold_off
    initial begin : result_side
        t_reply want;
        int     stall;
        stall = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_ready && o_valid) begin
                if (replies_due.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    compare_field("status", want.status, o_status);
                    compare_field("slot_index", want.slot, o_slot_index);
                    compare_field("found_pid", want.pid, o_found_pid);
                    compare_field("found_time", want.stamp, o_found_time);
                    compare_field("found_type", want.kind, o_found_type);
                    compare_field("entry_count", want.count, o_entry_count);
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                i_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 9) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        t_row row;
        int   i;
        int   n;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_cmd        = lph_pkg::CMD_INSERT;
        i_key        = '0;
        i_value_pid  = '0;
        i_value_time = '0;
        i_value_type = '0;
        for (i = 0; i < SLOTS; i++) shadow_valid[i] = 1'b0;
        shadow_count = 0;
        // half the pool crowds around the wrap point
        for (i = 0; i < POOL_SIZE; i++) begin
            if (i < 12) key_pool[i] = {25'($urandom), 6'((60 + i) % SLOTS)};
            else key_pool[i] = lph_pkg::KEY_W'($urandom);
        end

        add_row(lph_pkg::CMD_LOOKUP, 31'd0, 31'd0, 32'd0, 8'd0,
                TYPED, lph_pkg::ST_MISSING, 6'd0, 7'd0);
        add_row(lph_pkg::CMD_DELETE, 31'd5, 31'd0, 32'd0, 8'd0,
                TYPED, lph_pkg::ST_MISSING, 6'd0, 7'd0);
        add_row(lph_pkg::CMD_INSERT, 31'd0, 31'd0, 32'd0, 8'd0,
                TYPED, lph_pkg::ST_INSERTED, 6'd0, 7'd1);
        add_row(lph_pkg::CMD_INSERT, 31'd64, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                TYPED, lph_pkg::ST_INSERTED, 6'd1, 7'd2);
        add_row(lph_pkg::CMD_INSERT, 31'h7FFF_FFFF, 31'h2AAA_AAAA, 32'h5555_5555, 8'hA5,
                TYPED, lph_pkg::ST_INSERTED, 6'd63, 7'd3);
        add_row(lph_pkg::CMD_INSERT, 31'd127, 31'h1555_5555, 32'hAAAA_AAAA, 8'h5A,
                TYPED, lph_pkg::ST_INSERTED, 6'd2, 7'd4);
        add_row(lph_pkg::CMD_LOOKUP, 31'd64, 31'd0, 32'd0, 8'd0,
                PREDICT, lph_pkg::ST_MISSING, 6'd0, 7'd0);
        add_row(lph_pkg::CMD_LOOKUP, 31'd127, 31'd0, 32'd0, 8'd0,
                PREDICT, lph_pkg::ST_MISSING, 6'd0, 7'd0);
        add_row(lph_pkg::CMD_INSERT, 31'd0, 31'd1234, 32'd5678, 8'd9,
                TYPED, lph_pkg::ST_UPDATED, 6'd0, 7'd4);
        add_row(lph_pkg::CMD_LOOKUP, 31'd0, 31'd0, 32'd0, 8'd0,
                PREDICT, lph_pkg::ST_MISSING, 6'd0, 7'd0);
        add_row(CMD_UNUSED, 31'd0, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                TYPED, lph_pkg::ST_MISSING, 6'd0, 7'd4);
        add_row(lph_pkg::CMD_DELETE, 31'd0, 31'd0, 32'd0, 8'd0,
                TYPED, lph_pkg::ST_DELETED, 6'd0, 7'd3);
        // chain broken by the delete above
        add_row(lph_pkg::CMD_LOOKUP, 31'd64, 31'd0, 32'd0, 8'd0,
                TYPED, lph_pkg::ST_MISSING, 6'd0, 7'd3);
        add_row(lph_pkg::CMD_LOOKUP, 31'd127, 31'd0, 32'd0, 8'd0,
                TYPED, lph_pkg::ST_MISSING, 6'd0, 7'd3);
        add_row(lph_pkg::CMD_LOOKUP, 31'h7FFF_FFFF, 31'd0, 32'd0, 8'd0,
                PREDICT, lph_pkg::ST_MISSING, 6'd0, 7'd0);
        add_row(lph_pkg::CMD_INSERT, 31'd64, 31'd77, 32'h8000_0000, 8'h80,
                TYPED, lph_pkg::ST_INSERTED, 6'd0, 7'd4);
        add_row(lph_pkg::CMD_LOOKUP, 31'd64, 31'd0, 32'd0, 8'd0,
                PREDICT, lph_pkg::ST_MISSING, 6'd0, 7'd0);
        add_row(lph_pkg::CMD_DELETE, 31'd64, 31'd0, 32'd0, 8'd0,
                TYPED, lph_pkg::ST_DELETED, 6'd0, 7'd3);
        add_row(lph_pkg::CMD_DELETE, 31'd64, 31'd0, 32'd0, 8'd0,
                TYPED, lph_pkg::ST_MISSING, 6'd0, 7'd3);
        add_row(lph_pkg::CMD_INSERT, 31'd1, 31'h4000_0000, 32'h0000_0001, 8'h01,
                TYPED, lph_pkg::ST_INSERTED, 6'd3, 7'd4);
        add_row(lph_pkg::CMD_DELETE, 31'h7FFF_FFFF, 31'd0, 32'd0, 8'd0,
                TYPED, lph_pkg::ST_DELETED, 6'd63, 7'd3);
        add_row(lph_pkg::CMD_DELETE, 31'd127, 31'd0, 32'd0, 8'd0,
                TYPED, lph_pkg::ST_MISSING, 6'd0, 7'd3);
        add_row(lph_pkg::CMD_LOOKUP, 31'd1, 31'd0, 32'd0, 8'd0,
                PREDICT, lph_pkg::ST_MISSING, 6'd0, 7'd0);
        add_row(CMD_UNUSED, 31'h7FFF_FFFF, 31'd0, 32'd0, 8'd0,
                TYPED, lph_pkg::ST_MISSING, 6'd0, 7'd3);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < directed_rows.size(); i++) begin
            row = directed_rows[i];
            send_op(row.op, row.typed, row.reply);
        end

        // mixed traffic on a small key pool
        for (i = 0; i < 240; i++) send_op(make_op(mixed_cmd(), pool_key()), PREDICT, '0);

        // fill the table, then push past full
        while (shadow_count < SLOTS) begin
            send_op(make_op(lph_pkg::CMD_INSERT, lph_pkg::KEY_W'($urandom)), PREDICT, '0);
        end
        for (i = 0; i < 10; i++) begin
            send_op(make_op(lph_pkg::CMD_INSERT, lph_pkg::KEY_W'($urandom)), PREDICT, '0);
        end
        for (i = 0; i < 40; i++) begin
            n = $urandom_range(0, 99);
            if (n < 50) send_op(make_op(mixed_cmd(), stored_key()), PREDICT, '0);
            else send_op(make_op(mixed_cmd(), lph_pkg::KEY_W'($urandom)), PREDICT, '0);
        end

        wait_all_replies();

        // long hold on the result side while items keep coming
        hold_off = 300;
        for (i = 0; i < 130; i++) begin
            n = $urandom_range(0, 99);
            if (n < 60) send_op(make_op(lph_pkg::CMD_DELETE, stored_key()), PREDICT, '0);
            else if (n < 80) send_op(make_op(lph_pkg::CMD_LOOKUP, stored_key()), PREDICT, '0);
            else send_op(make_op(mixed_cmd(), pool_key()), PREDICT, '0);
        end

        idle_on = 1'b0;
        for (i = 0; i < 100; i++) begin
            if ($urandom_range(0, 1) == 0) send_op(make_op(mixed_cmd(), pool_key()), PREDICT, '0);
            else send_op(make_op(mixed_cmd(), stored_key()), PREDICT, '0);
        end

        wait_all_replies();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lph_pkg.sv
rtl/lph_mod_unit.sv
rtl/lph_store.sv
rtl/linear_probe_hash_table.sv
tb/sv/linear_probe_hash_table_tb.sv
